### hdl/sesm_pkg.sv
// Shared types and constants for the sized endian scratchpad memory core.
// Used by the top level; no dependencies.
package sesm_pkg;

    localparam int MEM_BYTES_DEFAULT = 65536;
    localparam int LANES             = 8;
    localparam int LANE_BITS         = 3;
    localparam int WORD_BYTES        = 4;
    localparam int ADDR_BITS         = 32;
    localparam int DATA_BITS         = 64;
    localparam int OFF_BITS          = ADDR_BITS + 2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_STORE = 1'b1;

    localparam logic [1:0] SIZE_WORD = 2'd2;

    typedef struct packed {
        logic                 op;
        logic                 ok;
        logic                 byte_swap;
        logic [1:0]           size_code;
        logic [LANE_BITS-1:0] lane0;
    } access_t;

endpackage

### hdl/sesm_ram.sv
// Generic single-port synchronous RAM with a registered read port.
// No dependencies.
module sesm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                                    clk,
    input  logic                                    en,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                        wdata,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/sized_endian_scratchpad_memory_core.sv
// Top level of the sized endian scratchpad memory core.
// Depends on sesm_pkg and sesm_ram (eight byte-lane banks).
//
//  channel  | direction | tdata                          | tuser
//  s_axis   | in        | address[31:0] write_data[95:32] | op[0] size_code[2:1]
//           |           |                                | word_mode[3] byte_swap[4]
//  m_axis   | out       | read_data[63:0]                | in_bounds[0]
//
// One item can be accepted every cycle while the output is not stalled. The bank read and
// the stage register load when an item is accepted; the output register loads from that
// stage when it advances and offers the result. Byte i of memory lives in bank i mod 8,
// so any access of up to eight bytes touches each bank port once.
// Reset clears only the pipeline valid bits; memory contents are undefined until written.
// A stalled output holds the result; one more item is taken into the bank read stage, whose
// read data is then held, and input acceptance stops until the output moves.
module sized_endian_scratchpad_memory_core #(
    parameter int MEM_BYTES = sesm_pkg::MEM_BYTES_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,  // address[31:0], write_data[95:32]
    input  logic [4:0]   s_axis_tuser,  // op, size_code[1:0], word_mode, byte_swap
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,  // read_data[63:0]
    output logic [0:0]   m_axis_tuser   // in_bounds
);

    localparam int ROWS = (MEM_BYTES + sesm_pkg::LANES - 1) / sesm_pkg::LANES;
    localparam int RW   = ROWS > 1 ? $clog2(ROWS) : 1;
    localparam int LB   = sesm_pkg::LANE_BITS;

    logic                            op;
    logic [1:0]                      size_code;
    logic [sesm_pkg::ADDR_BITS-1:0]  address;
    logic                            word_mode;
    logic                            byte_swap;
    logic [sesm_pkg::DATA_BITS-1:0]  write_data;

    logic [1:0]                      sc_eff;
    logic                            be_eff;
    logic [sesm_pkg::OFF_BITS-1:0]   offset;
    logic [3:0]                      nbytes;
    logic [sesm_pkg::OFF_BITS:0]     end_addr;
    logic                            ok;
    logic [LB-1:0]                   lane0;
    logic [RW-1:0]                   row0;
    logic                            accept;
    logic                            advance;

    logic [RW-1:0]                   lane_addr  [sesm_pkg::LANES];
    logic [7:0]                      lane_wdata [sesm_pkg::LANES];
    logic                            lane_we    [sesm_pkg::LANES];
    logic [7:0]                      lane_rdata [sesm_pkg::LANES];

    sesm_pkg::access_t               s1_reg;
    sesm_pkg::access_t               s1_next;
    logic                            s1_valid_reg;
    logic                            s1_valid_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [sesm_pkg::DATA_BITS-1:0]  out_data_reg;
    logic [sesm_pkg::DATA_BITS-1:0]  out_data_next;
    logic                            out_ok_reg;
    logic                            out_ok_next;

    logic [3:0]                      s1_nbytes;
    logic [sesm_pkg::DATA_BITS-1:0]  load_value;

    assign op         = s_axis_tuser[0];
    assign size_code  = s_axis_tuser[2:1];
    assign word_mode  = s_axis_tuser[3];
    assign byte_swap  = s_axis_tuser[4];
    assign address    = s_axis_tdata[31:0];
    assign write_data = s_axis_tdata[95:32];

    assign sc_eff   = word_mode ? sesm_pkg::SIZE_WORD : size_code;
    assign be_eff   = word_mode ? 1'b0 : byte_swap;
    assign offset   = word_mode ? {address, 2'b00} : {2'b00, address};
    assign nbytes   = 4'd1 << sc_eff;
    assign end_addr = {1'b0, offset} + {{(sesm_pkg::OFF_BITS - 3){1'b0}}, nbytes};
    assign ok       = end_addr <= (sesm_pkg::OFF_BITS + 1)'(MEM_BYTES);
    assign lane0    = offset[LB-1:0];
    assign row0     = offset[RW+LB-1:LB];

    assign advance       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        logic [LB-1:0] idx;
        logic [LB-1:0] pos;
        for (int b = 0; b < sesm_pkg::LANES; b++)
        begin
            idx = LB'(b) - lane0;
            pos = be_eff ? (LB'(nbytes - 4'd1) - idx) : idx;
            lane_addr[b]  = row0 + ((LB'(b) < lane0) ? RW'(1) : RW'(0));
            lane_wdata[b] = write_data[8*pos +: 8];
            lane_we[b]    = accept && (op == sesm_pkg::OP_STORE) && ok
                            && ({1'b0, idx} < nbytes);
        end
    end

    for (genvar g = 0; g < sesm_pkg::LANES; g++)
    begin : g_bank
        sesm_ram #(
            .WIDTH (8),
            .DEPTH (ROWS)
        ) u_bank (
            .clk   (clk),
            .en    (accept),
            .we    (lane_we[g]),
            .addr  (lane_addr[g]),
            .wdata (lane_wdata[g]),
            .rdata (lane_rdata[g])
        );
    end

    assign s1_nbytes = 4'd1 << s1_reg.size_code;

    always_comb
    begin
        logic [LB-1:0] pos;
        logic [LB-1:0] lane;
        load_value = '0;
        for (int p = 0; p < sesm_pkg::LANES; p++)
        begin
            pos  = s1_reg.byte_swap ? (LB'(s1_nbytes - 4'd1) - LB'(p)) : LB'(p);
            lane = s1_reg.lane0 + pos;
            if (4'(p) < s1_nbytes)
            begin
                load_value[8*p +: 8] = lane_rdata[lane];
            end
        end
    end

    always_comb
    begin
        s1_next        = s1_reg;
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_ok_next    = out_ok_reg;
        if (m_axis_tvalid && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_ok_next    = s1_reg.ok;
            out_data_next  = (s1_reg.ok && s1_reg.op == sesm_pkg::OP_LOAD) ? load_value : '0;
            s1_valid_next  = 1'b0;
        end
        if (accept)
        begin
            s1_valid_next        = 1'b1;
            s1_next.op           = op;
            s1_next.ok           = ok;
            s1_next.byte_swap    = be_eff;
            s1_next.size_code    = sc_eff;
            s1_next.lane0        = lane0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg       <= s1_next;
        out_data_reg <= out_data_next;
        out_ok_reg   <= out_ok_next;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_ok_reg;

endmodule
